[hw/rtl/ctc_pkg.sv]
// shared widths plus the stage-load and edge-result types for the circle/triangle collision pipeline
// no dependencies; imported by ctc_edge and circle_triangle_collision
package ctc_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned DOT_W   = PROD_W + 1;
  localparam int unsigned LEN_W   = SQ_W + 1;
  localparam int unsigned ACR_W   = SQ_W + 1;
  localparam int unsigned LO_W    = 17;
  localparam int unsigned HI_W    = ACR_W - LO_W;
  localparam int unsigned R2_W    = 2 * RAD_W;
  localparam int unsigned AA_W    = 2 * HI_W;
  localparam int unsigned AB_W    = HI_W + LO_W;
  localparam int unsigned BB_W    = 2 * LO_W;
  localparam int unsigned RL_W    = R2_W + HI_W;
  localparam int unsigned RR_W    = R2_W + LO_W;
  localparam int unsigned ACR2_W  = 2 * ACR_W;
  localparam int unsigned BOUND_W = 64;
  localparam int unsigned SUM_W   = RAD_W + 1;
  localparam int unsigned SUM2_W  = 2 * SUM_W;
  localparam int unsigned DIST_W  = SQ_W + 1;

  // stages inside one edge unit, plus the output register in the top level
  localparam int unsigned EDGE_STAGES = 5;
  localparam int unsigned NUM_STAGES  = EDGE_STAGES + 1;

  typedef struct packed {
    logic [EDGE_STAGES-1:0] ld;
  } ctc_adv_t;

  typedef struct packed {
    logic touch;
    logic cr_pos;
    logic cr_neg;
  } ctc_edge_res_t;

endpackage

[hw/rtl/ctc_edge.sv]
// one edge of the triangle against the circle, five register stages
// depends on ctc_pkg; stage loads come from the top level pipeline control
module ctc_edge import ctc_pkg::*; (
  input  logic                      clk_i,
  input  ctc_adv_t                  adv_i,
  input  logic signed [COORD_W-1:0] s_x_i,
  input  logic signed [COORD_W-1:0] s_y_i,
  input  logic signed [COORD_W-1:0] e_x_i,
  input  logic signed [COORD_W-1:0] e_y_i,
  input  logic signed [COORD_W-1:0] c_x_i,
  input  logic signed [COORD_W-1:0] c_y_i,
  input  logic        [RAD_W-1:0]   radius_i,
  output ctc_edge_res_t             res_o
);

  // stage 0: differences
  logic signed [DIFF_W-1:0] qx_q, qy_q, dx_q, dy_q, wx_q, wy_q;
  logic [RAD_W-1:0]         r_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.ld[0]) begin
      qx_q <= DIFF_W'(e_x_i) - DIFF_W'(c_x_i);
      qy_q <= DIFF_W'(e_y_i) - DIFF_W'(c_y_i);
      dx_q <= DIFF_W'(e_x_i) - DIFF_W'(s_x_i);
      dy_q <= DIFF_W'(e_y_i) - DIFF_W'(s_y_i);
      wx_q <= DIFF_W'(c_x_i) - DIFF_W'(s_x_i);
      wy_q <= DIFF_W'(c_y_i) - DIFF_W'(s_y_i);
      r_q  <= radius_i;
    end
  end

  // stage 1: products
  logic signed [PROD_W-1:0] qx2_full, qy2_full, dx2_full, dy2_full;
  logic [SQ_W-1:0]          qx2_q, qy2_q, dx2_q, dy2_q;
  logic signed [PROD_W-1:0] pdot_x_q, pdot_y_q, pcr_a_q, pcr_b_q;
  logic [R2_W-1:0]          r2_1_q;

  assign qx2_full = PROD_W'(qx_q) * PROD_W'(qx_q);
  assign qy2_full = PROD_W'(qy_q) * PROD_W'(qy_q);
  assign dx2_full = PROD_W'(dx_q) * PROD_W'(dx_q);
  assign dy2_full = PROD_W'(dy_q) * PROD_W'(dy_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.ld[1]) begin
      qx2_q    <= qx2_full[SQ_W-1:0];
      qy2_q    <= qy2_full[SQ_W-1:0];
      dx2_q    <= dx2_full[SQ_W-1:0];
      dy2_q    <= dy2_full[SQ_W-1:0];
      pdot_x_q <= PROD_W'(wx_q) * PROD_W'(dx_q);
      pdot_y_q <= PROD_W'(wy_q) * PROD_W'(dy_q);
      pcr_a_q  <= PROD_W'(dx_q) * PROD_W'(wy_q);
      pcr_b_q  <= PROD_W'(dy_q) * PROD_W'(wx_q);
      r2_1_q   <= R2_W'(r_q) * R2_W'(r_q);
    end
  end

  // stage 2: sums, vertex and projection tests, cross magnitude
  logic [LEN_W-1:0]        qd, len2;
  logic signed [DOT_W-1:0] dot, cr, neg_cr;
  logic                    dot_ok;
  logic [ACR_W-1:0]        acr;

  assign qd     = LEN_W'(qx2_q) + LEN_W'(qy2_q);
  assign len2   = LEN_W'(dx2_q) + LEN_W'(dy2_q);
  assign dot    = DOT_W'(pdot_x_q) + DOT_W'(pdot_y_q);
  assign cr     = DOT_W'(pcr_a_q) - DOT_W'(pcr_b_q);
  assign neg_cr = -cr;
  assign dot_ok = !dot[DOT_W-1] && (dot[DOT_W-2:0] <= (DOT_W-1)'(len2)) && (len2 != '0);
  assign acr    = cr[DOT_W-1] ? neg_cr[ACR_W-1:0] : cr[ACR_W-1:0];

  logic             vtx_2_q, span_2_q, pos_2_q, neg_2_q;
  logic [LEN_W-1:0] len2_q;
  logic [ACR_W-1:0] acr_q;
  logic [R2_W-1:0]  r2_2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.ld[2]) begin
      vtx_2_q  <= qd <= LEN_W'(r2_1_q);
      span_2_q <= dot_ok;
      pos_2_q  <= !cr[DOT_W-1] && (cr != '0);
      neg_2_q  <= cr[DOT_W-1];
      len2_q   <= len2;
      acr_q    <= acr;
      r2_2_q   <= r2_1_q;
    end
  end

  // stage 3: partial products of cross^2 and r^2 * len^2
  logic [HI_W-1:0] acr_hi, len_hi;
  logic [LO_W-1:0] acr_lo, len_lo;

  assign acr_hi = acr_q[ACR_W-1:LO_W];
  assign acr_lo = acr_q[LO_W-1:0];
  assign len_hi = len2_q[LEN_W-1:LO_W];
  assign len_lo = len2_q[LO_W-1:0];

  logic [AA_W-1:0] aa_q;
  logic [AB_W-1:0] ab_q;
  logic [BB_W-1:0] bb_q;
  logic [RL_W-1:0] rl_q;
  logic [RR_W-1:0] rr_q;
  logic            vtx_3_q, span_3_q, pos_3_q, neg_3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.ld[3]) begin
      aa_q     <= AA_W'(acr_hi) * AA_W'(acr_hi);
      ab_q     <= AB_W'(acr_hi) * AB_W'(acr_lo);
      bb_q     <= BB_W'(acr_lo) * BB_W'(acr_lo);
      rl_q     <= RL_W'(r2_2_q) * RL_W'(len_hi);
      rr_q     <= RR_W'(r2_2_q) * RR_W'(len_lo);
      vtx_3_q  <= vtx_2_q;
      span_3_q <= span_2_q;
      pos_3_q  <= pos_2_q;
      neg_3_q  <= neg_2_q;
    end
  end

  // stage 4: assemble the wide terms
  logic [ACR2_W-1:0]  acr2_q;
  logic [BOUND_W-1:0] bound_q;
  logic               vtx_4_q, span_4_q, pos_4_q, neg_4_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.ld[4]) begin
      acr2_q   <= (ACR2_W'(aa_q) << (2 * LO_W)) + (ACR2_W'(ab_q) << (LO_W + 1))
                  + ACR2_W'(bb_q);
      bound_q  <= (BOUND_W'(rl_q) << LO_W) + BOUND_W'(rr_q);
      vtx_4_q  <= vtx_3_q;
      span_4_q <= span_3_q;
      pos_4_q  <= pos_3_q;
      neg_4_q  <= neg_3_q;
    end
  end

  assign res_o.touch  = vtx_4_q || (span_4_q && (acr2_q <= ACR2_W'(bound_q)));
  assign res_o.cr_pos = pos_4_q;
  assign res_o.cr_neg = neg_4_q;

endmodule

[hw/rtl/circle_triangle_collision.sv]
// Circle against triangle collision test. One beat per cycle sustained while the output is
// not stalled; the depth is set by the exact squaring of the edge cross product and the
// radius-times-length product, split into partial products over two stages. Each input
// beat yields exactly one hit beat, in order; a stalled output freezes the pipeline while
// empty stages keep filling.
// top level; depends on ctc_pkg and ctc_edge
module circle_triangle_collision import ctc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic        [RAD_W-1:0]   radius_i,
  input  logic signed [COORD_W-1:0] apex_x_i,
  input  logic signed [COORD_W-1:0] apex_y_i,
  input  logic signed [COORD_W-1:0] second_x_i,
  input  logic signed [COORD_W-1:0] second_y_i,
  input  logic signed [COORD_W-1:0] third_x_i,
  input  logic signed [COORD_W-1:0] third_y_i,
  input  logic        [RAD_W-1:0]   reach_radius_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o
);

  // pipeline control
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES:0]   ready;
  ctc_adv_t              adv;

  always_comb begin
    ready[NUM_STAGES] = !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign valid_d    = {valid_q[NUM_STAGES-2:0], in_valid_i};
  assign adv.ld     = ready[EDGE_STAGES-1:0];
  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (ready[k]) valid_q[k] <= valid_d[k];
      end
    end
  end

  // edge units
  ctc_edge_res_t res_ab, res_at, res_bt;

  ctc_edge u_edge_ab (
    .clk_i, .adv_i(adv),
    .s_x_i(apex_x_i), .s_y_i(apex_y_i), .e_x_i(second_x_i), .e_y_i(second_y_i),
    .c_x_i(center_x_i), .c_y_i(center_y_i), .radius_i, .res_o(res_ab)
  );

  ctc_edge u_edge_at (
    .clk_i, .adv_i(adv),
    .s_x_i(apex_x_i), .s_y_i(apex_y_i), .e_x_i(third_x_i), .e_y_i(third_y_i),
    .c_x_i(center_x_i), .c_y_i(center_y_i), .radius_i, .res_o(res_at)
  );

  ctc_edge u_edge_bt (
    .clk_i, .adv_i(adv),
    .s_x_i(second_x_i), .s_y_i(second_y_i), .e_x_i(third_x_i), .e_y_i(third_y_i),
    .c_x_i(center_x_i), .c_y_i(center_y_i), .radius_i, .res_o(res_bt)
  );

  // quick rejection around the apex
  logic signed [DIFF_W-1:0] adx_q, ady_q;
  logic [SUM_W-1:0]         sum_q;
  logic signed [PROD_W-1:0] adx2_full, ady2_full;
  logic [SQ_W-1:0]          adx2_q, ady2_q;
  logic [SUM2_W-1:0]        sum2_q;
  logic [DIST_W-1:0]        dist2;
  logic                     rej_2_q, rej_3_q, rej_4_q;
  logic                     in_tri;
  logic                     hit_q;

  assign adx2_full = PROD_W'(adx_q) * PROD_W'(adx_q);
  assign ady2_full = PROD_W'(ady_q) * PROD_W'(ady_q);
  assign dist2     = DIST_W'(adx2_q) + DIST_W'(ady2_q);

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      adx_q <= DIFF_W'(apex_x_i) - DIFF_W'(center_x_i);
      ady_q <= DIFF_W'(apex_y_i) - DIFF_W'(center_y_i);
      sum_q <= SUM_W'(radius_i) + SUM_W'(reach_radius_i);
    end
    if (ready[1]) begin
      adx2_q <= adx2_full[SQ_W-1:0];
      ady2_q <= ady2_full[SQ_W-1:0];
      sum2_q <= SUM2_W'(sum_q) * SUM2_W'(sum_q);
    end
    if (ready[2]) rej_2_q <= dist2 > DIST_W'(sum2_q);
    if (ready[3]) rej_3_q <= rej_2_q;
    if (ready[4]) rej_4_q <= rej_3_q;
    if (ready[5]) hit_q   <= !rej_4_q && (res_ab.touch || res_at.touch || res_bt.touch
                                          || in_tri);
  end

  // counterclockwise containment: center on or left of apex->second and second->third, on or right of apex->third
  assign in_tri = !res_ab.cr_neg && !res_bt.cr_neg && !res_at.cr_pos;

  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign hit_o       = hit_q;

  // an empty output stage means every stage can take a beat
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with drained output stage");

  // with the output free, an accepted beat arrives after the full depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // beats in flight are conserved while nothing enters or leaves
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_stall_i && !(in_valid_i && !in_stall_o))
    |=> $countones(valid_q) == $past($countones(valid_q)))
    else $error("beat lost or duplicated inside the pipeline");

endmodule
